// ===== design/css_pkg.sv =====
// shared types and constants for the cosine similarity stream core
package css_pkg;

  localparam int ELEM_W     = 16;
  localparam int SIM_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int SUM_W      = 48;
  localparam int MAX_DIM    = 4096;
  localparam int COUNT_W    = $clog2(MAX_DIM + 1);
  localparam int MAG_W      = 43;
  localparam int LIMB_W     = 22;
  localparam int HI_W       = MAG_W - LIMB_W;
  localparam int PROD_W     = 2 * LIMB_W;
  localparam int FRAC_SHIFT = 60;
  localparam int WIDE_W     = FRAC_SHIFT + 2 * LIMB_W + PROD_W;
  localparam int Q_W        = 31;
  localparam int BIT_W      = $clog2(Q_W);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_NORM = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_t;

endpackage

// ===== design/css_if.sv =====
// element and result channel interfaces
interface css_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [css_pkg::ELEM_W-1:0] a_element;
  logic signed [css_pkg::ELEM_W-1:0] b_element;
  logic                              last_element;
  modport source (output valid, a_element, b_element, last_element, input ready);
  modport sink (input valid, a_element, b_element, last_element, output ready);
endinterface

interface css_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [css_pkg::SIM_W-1:0]  similarity;
  logic [css_pkg::STATUS_W-1:0]      status;
  modport source (output valid, similarity, status, input ready);
  modport sink (input valid, similarity, status, output ready);
endinterface

// ===== design/cosine_similarity_stream_core.sv =====
// cosine similarity stream core: accumulation, wide products and bitwise root-ratio search
//
//   channel   dir   beat payload                              handshake
//   elem      in    a_element, b_element, last_element        valid/ready
//   result    out   similarity, status                        valid/ready
//
// an element beat runs MUL_AA, MUL_BB, MUL_AB and MUL_ACC after IDLE, using
// one 22x22 multiplier three times; a beat past the length limit skips the multiply
// a last beat then runs CHECK and the wide products in WIDE_MUL on the same
// multiplier, then the 31-bit search, ROOT_SUM and ROOT_TEST per bit on the 148-bit adder
// rst is synchronous and clears all sums, the count and the result valid
// result stalls do not block elements; a last beat waits only if the
// previous result is still held
module cosine_similarity_stream_core (
  input  logic            clk,
  input  logic            rst,
  css_in_if.sink          elem,
  css_out_if.source       result
);

  typedef enum logic [3:0] {
    IDLE, MUL_AA, MUL_BB, MUL_AB, MUL_ACC, CHECK, WIDE_MUL, ROOT_SUM, ROOT_TEST, DONE
  } state_t;

  state_t                          state;
  logic [css_pkg::ELEM_W-1:0]      a_mag;
  logic [css_pkg::ELEM_W-1:0]      b_mag;
  logic                            prod_neg;
  logic                            last;
  logic [css_pkg::SUM_W-1:0]       dot_sum;
  logic [css_pkg::SUM_W-1:0]       norm_a_sum;
  logic [css_pkg::SUM_W-1:0]       norm_b_sum;
  logic [css_pkg::COUNT_W-1:0]     element_count;
  logic                            length_exceeded;
  logic [css_pkg::MAG_W-1:0]       dot_mag;
  logic                            dot_neg;
  logic [3:0]                      pp_idx;
  logic [css_pkg::PROD_W-1:0]      prod;
  logic [css_pkg::WIDE_W-1:0]      rem;
  logic [css_pkg::WIDE_W-1:0]      u_acc;
  logic [css_pkg::WIDE_W-1:0]      v_acc;
  logic [css_pkg::WIDE_W-1:0]      trial;
  logic [css_pkg::Q_W-1:0]         q;
  logic [css_pkg::BIT_W-1:0]       bit_k;
  css_pkg::status_t                status;

  logic [css_pkg::LIMB_W-1:0]      mul_x;
  logic [css_pkg::LIMB_W-1:0]      mul_y;
  logic [css_pkg::MAG_W-1:0]       src_x;
  logic [css_pkg::MAG_W-1:0]       src_y;
  logic [2:0]                      prev_idx;
  logic [css_pkg::WIDE_W-1:0]      addend;
  logic [css_pkg::WIDE_W-1:0]      wide_prod;
  logic [css_pkg::ELEM_W-1:0]      in_a_mag;
  logic [css_pkg::ELEM_W-1:0]      in_b_mag;
  logic [css_pkg::SUM_W-1:0]       dot_abs;

  assign elem.ready = (state == IDLE);

  assign in_a_mag = elem.a_element[css_pkg::ELEM_W-1] ?
                    css_pkg::ELEM_W'(-elem.a_element) : elem.a_element;
  assign in_b_mag = elem.b_element[css_pkg::ELEM_W-1] ?
                    css_pkg::ELEM_W'(-elem.b_element) : elem.b_element;
  assign dot_abs  = dot_sum[css_pkg::SUM_W-1] ? -dot_sum : dot_sum;

  // operand select for the shared multiplier
  always_comb begin
    src_x = pp_idx[2] ? dot_mag : norm_a_sum[css_pkg::MAG_W-1:0];
    src_y = pp_idx[2] ? dot_mag : norm_b_sum[css_pkg::MAG_W-1:0];
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      MUL_AA: begin
        mul_x = css_pkg::LIMB_W'(a_mag);
        mul_y = css_pkg::LIMB_W'(a_mag);
      end
      MUL_BB: begin
        mul_x = css_pkg::LIMB_W'(b_mag);
        mul_y = css_pkg::LIMB_W'(b_mag);
      end
      MUL_AB: begin
        mul_x = css_pkg::LIMB_W'(a_mag);
        mul_y = css_pkg::LIMB_W'(b_mag);
      end
      WIDE_MUL: begin
        mul_x = pp_idx[1] ? css_pkg::LIMB_W'(src_x[css_pkg::MAG_W-1:css_pkg::LIMB_W])
                          : src_x[css_pkg::LIMB_W-1:0];
        mul_y = pp_idx[0] ? css_pkg::LIMB_W'(src_y[css_pkg::MAG_W-1:css_pkg::LIMB_W])
                          : src_y[css_pkg::LIMB_W-1:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // placement of the previous partial product in the wide accumulators
  always_comb begin
    prev_idx  = 3'(pp_idx - 4'd1);
    wide_prod = css_pkg::WIDE_W'(prod);
    case ({1'b0, prev_idx[1]} + {1'b0, prev_idx[0]})
      2'd0:    addend = wide_prod << css_pkg::FRAC_SHIFT;
      2'd1:    addend = wide_prod << (css_pkg::FRAC_SHIFT + css_pkg::LIMB_W);
      default: addend = wide_prod << (css_pkg::FRAC_SHIFT + 2 * css_pkg::LIMB_W);
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
    if (rst) begin
      state           <= IDLE;
      result.valid    <= 1'b0;
      dot_sum         <= '0;
      norm_a_sum      <= '0;
      norm_b_sum      <= '0;
      element_count   <= '0;
      length_exceeded <= 1'b0;
      pp_idx          <= '0;
      bit_k           <= '0;
    end else begin
      if (result.valid && result.ready && state != DONE) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (elem.valid) begin
            a_mag    <= in_a_mag;
            b_mag    <= in_b_mag;
            prod_neg <= elem.a_element[css_pkg::ELEM_W-1] ^ elem.b_element[css_pkg::ELEM_W-1];
            last     <= elem.last_element;
            if (element_count >= css_pkg::COUNT_W'(css_pkg::MAX_DIM)) begin
              length_exceeded <= 1'b1;
              state           <= elem.last_element ? CHECK : IDLE;
            end else begin
              element_count <= element_count + 1'b1;
              state         <= MUL_AA;
            end
          end
        end
        MUL_AA: begin
          state <= MUL_BB;
        end
        MUL_BB: begin
          norm_a_sum <= norm_a_sum + css_pkg::SUM_W'(prod);
          state      <= MUL_AB;
        end
        MUL_AB: begin
          norm_b_sum <= norm_b_sum + css_pkg::SUM_W'(prod);
          state      <= MUL_ACC;
        end
        MUL_ACC: begin
          dot_sum <= prod_neg ? dot_sum - css_pkg::SUM_W'(prod)
                              : dot_sum + css_pkg::SUM_W'(prod);
          state   <= last ? CHECK : IDLE;
        end
        CHECK: begin
          q       <= '0;
          dot_mag <= dot_abs[css_pkg::MAG_W-1:0];
          dot_neg <= dot_sum[css_pkg::SUM_W-1];
          rem     <= '0;
          v_acc   <= '0;
          u_acc   <= '0;
          pp_idx  <= '0;
          if (length_exceeded) begin
            status <= css_pkg::STATUS_TOO_LONG;
            state  <= DONE;
          end else if (norm_a_sum == '0 || norm_b_sum == '0) begin
            status <= css_pkg::STATUS_ZERO_NORM;
            state  <= DONE;
          end else begin
            status <= css_pkg::STATUS_OK;
            state  <= WIDE_MUL;
          end
        end
        WIDE_MUL: begin
          if (pp_idx != '0) begin
            if (prev_idx[2]) begin
              rem <= rem + addend;
            end else begin
              v_acc <= v_acc + addend;
            end
          end
          pp_idx <= pp_idx + 1'b1;
          if (pp_idx == 4'd8) begin
            bit_k <= css_pkg::BIT_W'(css_pkg::Q_W - 1);
            state <= ROOT_SUM;
          end
        end
        ROOT_SUM: begin
          trial <= u_acc + v_acc;
          state <= ROOT_TEST;
        end
        ROOT_TEST: begin
          if (trial <= rem) begin
            rem      <= rem - trial;
            q[bit_k] <= 1'b1;
            u_acc    <= (u_acc >> 1) + v_acc;
          end else begin
            u_acc <= u_acc >> 1;
          end
          v_acc <= v_acc >> 2;
          if (bit_k == '0) begin
            state <= DONE;
          end else begin
            bit_k <= bit_k - 1'b1;
            state <= ROOT_SUM;
          end
        end
        DONE: begin
          if (!result.valid || result.ready) begin
            result.valid      <= 1'b1;
            result.status     <= status;
            result.similarity <= (status != css_pkg::STATUS_OK) ? '0 :
                                 dot_neg ? -css_pkg::SIM_W'(q) : css_pkg::SIM_W'(q);
            dot_sum           <= '0;
            norm_a_sum        <= '0;
            norm_b_sum        <= '0;
            element_count     <= '0;
            length_exceeded   <= 1'b0;
            state             <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != css_pkg::STATUS_OK |-> result.similarity == '0)
    else $error("faulted beat with non-zero similarity");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.similarity <= 32'sd1073741824 &&
                     result.similarity >= -32'sd1073741824)
    else $error("similarity outside unit range");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    element_count <= css_pkg::COUNT_W'(css_pkg::MAX_DIM))
    else $error("element count beyond limit");

  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    state == DONE && (!result.valid || result.ready) |=>
      element_count == '0 && dot_sum == '0 && !length_exceeded && result.valid)
    else $error("sums not cleared after result");

  a_search_range: assert property (@(posedge clk) disable iff (rst)
    state == ROOT_TEST |-> q <= css_pkg::Q_W'(32'h4000_0000))
    else $error("ratio search out of range");

endmodule
